### rtl/core/ordered_list_engine_unit_macros.svh
// Assertion macros used by the ordered list engine RTL.
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/olist_pkg.sv
// Shared types and codes for the ordered list engine.
`default_nettype none

package olist_pkg;

  localparam int VALUE_W = 32;

  // Request kinds.
  localparam logic [1:0] REQ_APPEND  = 2'd0;
  localparam logic [1:0] REQ_PREPEND = 2'd1;
  localparam logic [1:0] REQ_DELETE  = 2'd2;
  localparam logic [1:0] REQ_DUMP    = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_ENTRY    = 3'd3;
  localparam logic [2:0] ST_END      = 3'd4;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic                      shl;
    logic                      shr;
    logic                      wr_en;
    logic signed [VALUE_W-1:0] wr_data;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/olist_cell.sv
// One storage cell of the list chain.
`default_nettype none

module olist_cell
  import olist_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int PTR_W = 5
) (
  input  wire logic                      clk,
  input  wire cell_ctrl_t                ctrl,
  input  wire logic [PTR_W-1:0]          wr_pos,
  input  wire logic signed [VALUE_W-1:0] left_val,
  input  wire logic signed [VALUE_W-1:0] right_val,
  output logic signed [VALUE_W-1:0]      val
);

  logic hit;

  assign hit = ctrl.wr_en && (wr_pos == PTR_W'(IDX));

  // A direct write wins over the neighbor handoff.
  always_ff @(posedge clk) begin
    if (hit) begin
      val <= ctrl.wr_data;
    end else if (ctrl.shr) begin
      val <= left_val;
    end else if (ctrl.shl) begin
      val <= right_val;
    end
  end

endmodule

`default_nettype wire

### rtl/core/olist_chain.sv
// Row of list cells; entry zero is the head of the list.
`default_nettype none

module olist_chain
  import olist_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int PTR_W    = 5
) (
  input  wire logic                 clk,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic [PTR_W-1:0]     wr_pos,
  output logic signed [VALUE_W-1:0] head
);

  logic signed [VALUE_W-1:0] vals [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] lv;
    logic signed [VALUE_W-1:0] rv;

    if (i == 0) begin : g_first
      assign lv = ctrl.wr_data;
    end else begin : g_mid_l
      assign lv = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv = vals[i];
    end else begin : g_mid_r
      assign rv = vals[i+1];
    end

    olist_cell #(
      .IDX   (i),
      .PTR_W (PTR_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .wr_pos    (wr_pos),
      .left_val  (lv),
      .right_val (rv),
      .val       (vals[i])
    );
  end

  assign head = vals[0];

endmodule

`default_nettype wire

### rtl/core/ordered_list_engine_unit.sv
// Append, prepend and a delete or dump of an empty list go from accept straight to S_FIN.
// Delete rotates the chain once per entry in S_ROT, then gives its one result from S_FIN.
// Dump gives one entry per cycle from the head cell while the output is free; L + 1 results.
// One transaction in flight; the next is taken once the final result is in the output register.
// Reset empties the list at once; cell contents are not cleared and need no sweep.
`default_nettype none

module ordered_list_engine_unit
  import olist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                req_type,
  input  wire logic signed [VALUE_W-1:0] value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [VALUE_W-1:0]      item_value,
  output logic [2:0]                     status,
  output logic [4:0]                     entry_count,
  output logic                           last
);

  `include "ordered_list_engine_unit_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ROT  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                    state;
  logic [1:0]                req_q;
  logic signed [VALUE_W-1:0] key_q;
  logic [CNT_W-1:0]          list_length;
  logic [CNT_W-1:0]          steps;
  logic                      found;

  cell_ctrl_t                ctrl;
  logic [CNT_W-1:0]          wr_pos;
  logic signed [VALUE_W-1:0] head;
  logic                      out_free;
  logic                      step;
  logic                      drop;
  logic                      full;

  function automatic logic [4:0] cnt5(input logic [CNT_W-1:0] x);
    logic [CNT_W+4:0] w;
    w = {5'b0, x};
    return w[4:0];
  endfunction

  olist_chain #(
    .CAPACITY (CAPACITY),
    .PTR_W    (CNT_W)
  ) u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .wr_pos (wr_pos),
    .head   (head)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign full     = (list_length == CNT_W'(CAPACITY));
  assign step     = (state == S_ROT) && ((req_q == REQ_DELETE) || out_free);
  assign drop     = step && (req_q == REQ_DELETE) && !found && (head == key_q);

  // Delete and dump rotate the list: the head leaves cell zero and is written
  // back at the tail (except the first match of a delete), so after one lap the order is restored.
  always_comb begin
    ctrl         = '0;
    ctrl.wr_data = key_q;
    wr_pos       = list_length;
    if (step) begin
      ctrl.shl     = 1'b1;
      ctrl.wr_en   = !drop;
      ctrl.wr_data = head;
      wr_pos       = list_length - CNT_W'(1);
    end else if ((state == S_FIN) && out_free && !full) begin
      if (req_q == REQ_APPEND) begin
        ctrl.wr_en = 1'b1;
      end else if (req_q == REQ_PREPEND) begin
        ctrl.shr = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      list_length <= '0;
      steps       <= '0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q <= req_type;
            key_q <= value;
            found <= 1'b0;
            steps <= list_length;
            if (((req_type == REQ_DELETE) || (req_type == REQ_DUMP)) &&
                (list_length != '0)) begin
              state <= S_ROT;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_ROT: begin
          if (step) begin
            steps <= steps - CNT_W'(1);
            if (drop) begin
              list_length <= list_length - CNT_W'(1);
              found       <= 1'b1;
            end
            if (req_q == REQ_DUMP) begin
              out_valid   <= 1'b1;
              item_value  <= head;
              status      <= ST_ENTRY;
              entry_count <= cnt5(list_length);
              last        <= 1'b0;
            end
            if (steps == CNT_W'(1)) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            item_value  <= '0;
            last        <= 1'b1;
            entry_count <= cnt5(list_length);
            case (req_q)
              REQ_APPEND, REQ_PREPEND: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  status      <= ST_DONE;
                  list_length <= list_length + CNT_W'(1);
                  entry_count <= cnt5(list_length + CNT_W'(1));
                end
              end
              REQ_DELETE: begin
                status <= found ? ST_DONE : ST_NOTFOUND;
              end
              default: begin
                status <= ST_END;
              end
            endcase
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `OLE_ASSERT_NOW(a_len_in_range, 1'b1, list_length <= CNT_W'(CAPACITY),
                  "list length above capacity")
  `OLE_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state != S_IDLE,
                   "accepted transaction did not start")
  `OLE_ASSERT_NOW(a_full_only_at_cap, out_valid && (status == ST_FULL),
                  entry_count == 5'(CAPACITY), "full reported below capacity")
  `OLE_ASSERT_NOW(a_rot_has_steps, state == S_ROT, steps != '0,
                  "rotation running with no steps left")

endmodule

`default_nettype wire

### tb/ordered_list_engine_unit_test.sv
// Self-checking testbench for the ordered list engine: directed and random request traffic.
`default_nettype none

module ordered_list_engine_unit_test;
  import olist_pkg::*;

  localparam int LIST_CAP = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [VALUE_W-1:0] item_value;
    logic [2:0]                status;
    logic [4:0]                entry_count;
    logic                      last;
  } list_result_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                req_type;
  logic signed [VALUE_W-1:0] value;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [VALUE_W-1:0] item_value;
  logic [2:0]                status;
  logic [4:0]                entry_count;
  logic                      last;

  // Software copy of the list contents, head first.
  logic signed [VALUE_W-1:0] list_shadow[$];
  list_result_t              pending_results[$];
  int                        error_count = 0;
  int                        cycle_count = 0;
  int                        send_idle_pct = 0;
  int                        recv_idle_pct = 0;

  ordered_list_engine_unit #(.CAPACITY(LIST_CAP)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .item_value  (item_value),
    .status      (status),
    .entry_count (entry_count),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever @(posedge clk) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("ordered_list_engine_unit_test failed");
        $finish;
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever @(negedge clk) begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void push_result(logic signed [VALUE_W-1:0] v, logic [2:0] st,
                                      logic lst);
    list_result_t r;
    r.item_value  = v;
    r.status      = st;
    r.entry_count = 5'(list_shadow.size());
    r.last        = lst;
    pending_results.push_back(r);
  endfunction

  // Applies one accepted request to the shadow list and queues the results it causes.
  function automatic void apply_list_request(logic [1:0] kind, logic signed [VALUE_W-1:0] key);
    int idx;
    idx = -1;
    case (kind)
      REQ_APPEND, REQ_PREPEND: begin
        if (list_shadow.size() >= LIST_CAP) begin
          push_result('0, ST_FULL, 1'b1);
        end else begin
          if (kind == REQ_APPEND) list_shadow.push_back(key);
          else list_shadow.push_front(key);
          push_result('0, ST_DONE, 1'b1);
        end
      end
      REQ_DELETE: begin
        for (int i = 0; i < list_shadow.size(); i++) begin
          if (idx < 0 && list_shadow[i] == key) idx = i;
        end
        if (idx < 0) begin
          push_result('0, ST_NOTFOUND, 1'b1);
        end else begin
          list_shadow.delete(idx);
          push_result('0, ST_DONE, 1'b1);
        end
      end
      default: begin
        foreach (list_shadow[i]) push_result(list_shadow[i], ST_ENTRY, 1'b0);
        push_result('0, ST_END, 1'b1);
      end
    endcase
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic signed [VALUE_W-1:0] key);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = kind;
    value    = key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_list_request(kind, key);
  endtask

  // Compares every completed output transaction with the oldest queued result.
  initial begin
    list_result_t exp_r;
    forever @(posedge clk) begin
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: item_value %0d status %0d entry_count %0d last %0b",
                 item_value, status, entry_count, last);
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (item_value !== exp_r.item_value) begin
            $error("item_value: expected %0d, actual %0d", exp_r.item_value, item_value);
            error_count++;
          end
          if (status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, status);
            error_count++;
          end
          if (entry_count !== exp_r.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", exp_r.entry_count, entry_count);
            error_count++;
          end
          if (last !== exp_r.last) begin
            $error("last: expected %0b, actual %0b", exp_r.last, last);
            error_count++;
          end
        end
      end
    end
  end

  task automatic test_empty_list();
    send_request(REQ_DUMP, 32'sd0);
    send_request(REQ_DELETE, 32'sd7);
  endtask

  task automatic test_edge_values();
    send_request(REQ_APPEND, 32'sh7FFF_FFFF);
    send_request(REQ_PREPEND, 32'sh8000_0000);
    send_request(REQ_APPEND, -32'sd1);
    send_request(REQ_PREPEND, 32'sd0);
    send_request(REQ_DUMP, 32'sh7FFF_FFFF);
  endtask

  // Only the first of two equal entries may be removed.
  task automatic test_duplicate_delete();
    send_request(REQ_APPEND, 32'sd5);
    send_request(REQ_PREPEND, 32'sd5);
    send_request(REQ_DELETE, 32'sd5);
    send_request(REQ_DELETE, 32'sd123);
    send_request(REQ_DUMP, -32'sd1);
  endtask

  task automatic test_full_list();
    int k;
    k = 0;
    while (list_shadow.size() < LIST_CAP) begin
      send_request((k % 2 == 0) ? REQ_APPEND : REQ_PREPEND, 32'shA5A5_0000 + k);
      k++;
    end
    send_request(REQ_APPEND, 32'sd1);
    send_request(REQ_PREPEND, 32'sd2);
    send_request(REQ_DUMP, 32'sd0);
  endtask

  // Alternates between filling and draining bursts so that both the full and the
  // empty list come up often; delete keys mostly hit an entry that is present.
  task automatic test_random_traffic(input int num_items);
    int                        pick;
    int                        insert_pct;
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] key;
    for (int n = 0; n < num_items; n++) begin
      insert_pct = ((n / 16) % 2 == 0) ? 65 : 25;
      pick = $urandom_range(99);
      if (pick < insert_pct) kind = ($urandom_range(1) == 0) ? REQ_APPEND : REQ_PREPEND;
      else if (pick < 88) kind = REQ_DELETE;
      else kind = REQ_DUMP;
      if ($urandom_range(99) < 30) key = $signed(32'($urandom_range(6))) - 32'sd3;
      else key = $urandom;
      if (kind == REQ_DELETE && list_shadow.size() > 0 && $urandom_range(99) < 75) begin
        key = list_shadow[$urandom_range(list_shadow.size() - 1)];
      end
      send_request(kind, key);
    end
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_APPEND;
    value    = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 35;
    recv_idle_pct = 54;
    test_empty_list();
    test_edge_values();
    test_duplicate_delete();
    test_full_list();
    test_random_traffic(62);

    send_idle_pct = 54;
    recv_idle_pct = 35;
    test_random_traffic(62);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(62);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("ordered_list_engine_unit_test passed");
    end else begin
      $display("ordered_list_engine_unit_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/olist_pkg.sv
rtl/core/olist_cell.sv
rtl/core/olist_chain.sv
rtl/core/ordered_list_engine_unit.sv
tb/ordered_list_engine_unit_test.sv
